/* hdl/smr_pkg.sv */
// ----------------------------------------------------------------------------
// smr_pkg: shared types and constants
// Command codes, mixing constants and sequencer states of the feedback
// splitmix generator with ranged output.
// ----------------------------------------------------------------------------
package smr_pkg;

  // Command codes carried in the cmd field
  localparam logic [1:0] CMD_NEXT   = 2'd0;
  localparam logic [1:0] CMD_RANGE  = 2'd1;
  localparam logic [1:0] CMD_RESEED = 2'd2;

  // Golden-ratio increment and finalizer multipliers
  localparam logic [63:0] GAMMA_ADD = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_B = 64'h94d049bb133111eb;

  // Sequencer states of the top level
  typedef enum logic [2:0] {
    S_IDLE,
    S_MIX1,
    S_WAIT1,
    S_MIX2,
    S_WAIT2,
    S_DIV,
    S_WAITD,
    S_DONE
  } smr_state_t;

endpackage

/* hdl/smr_if.sv */
// ----------------------------------------------------------------------------
// smr_in_if / smr_out_if: request and result channels
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface smr_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [63:0]        seed_value;
  logic signed [31:0] range_min;
  logic signed [31:0] range_max;

  modport source (output valid, cmd, seed_value, range_min, range_max, input ready);
  modport sink   (input valid, cmd, seed_value, range_min, range_max, output ready);
endinterface

interface smr_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic        seed_changed;
  logic        range_error;

  modport source (output valid, value, seed_changed, range_error, input ready);
  modport sink   (input valid, value, seed_changed, range_error, output ready);
endinterface

/* hdl/smr_mul.sv */
// ----------------------------------------------------------------------------
// smr_mul: iterative 64x64 multiplier, low 64 bits of the product
// One 32x32 multiplier is reused over three partial products; the
// cross terms only contribute their low halves to the upper word.
// ----------------------------------------------------------------------------
module smr_mul
  import smr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] product
);

  logic [63:0] a_r;
  logic [63:0] b_r;
  logic [63:0] pp;
  logic [63:0] acc;
  logic [1:0]  phase;
  logic        busy;
  logic [31:0] op_x;
  logic [31:0] op_y;
  logic [63:0] mul_full;

  // Pick the operand halves for the current partial product
  assign op_x     = (phase == 2'd2) ? a_r[63:32] : a_r[31:0];
  assign op_y     = (phase == 2'd1) ? b_r[63:32] : b_r[31:0];
  assign mul_full = op_x * op_y;
  assign product  = acc;

  // Control: four busy phases, then a done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 2'd0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        phase <= 2'd0;
      end else if (busy) begin
        phase <= phase + 2'd1;
        if (phase == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: register each partial product, accumulate it the cycle after
  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
    end
    if (busy) begin
      pp <= mul_full;
      case (phase)
        2'd0:    acc <= acc;
        2'd1:    acc <= pp;
        default: acc <= acc + {pp[31:0], 32'd0};
      endcase
    end
  end

endmodule

/* hdl/smr_mod.sv */
// ----------------------------------------------------------------------------
// smr_mod: serial remainder unit
// Restoring division of a 64-bit word by a 33-bit span, one quotient
// bit per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
module smr_mod
  import smr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [32:0] divisor,
  output logic        done,
  output logic [32:0] rem
);

  logic [63:0] dvd;
  logic [32:0] dsr;
  logic [6:0]  cnt;
  logic        busy;
  logic [33:0] trial;
  logic [33:0] diff;

  // Shift in the next dividend bit and try the subtraction
  assign trial = {rem, dvd[63]};
  assign diff  = trial - {1'b0, dsr};

  // Control: 64 iterations, then a done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 7'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd64;
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: keep the partial remainder below the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= 33'd0;
    end else if (busy) begin
      dvd <= {dvd[62:0], 1'b0};
      if (trial >= {1'b0, dsr}) begin
        rem <= diff[32:0];
      end else begin
        rem <= trial[32:0];
      end
    end
  end

endmodule

/* hdl/splitmix_feedback_rng_range_top.sv */
// ----------------------------------------------------------------------------
// splitmix_feedback_rng_range_top: feedback splitmix generator with range
// Adds the golden-ratio gamma to the seed, runs the two multiply-xorshift
// rounds, feeds the mix back as the seed and optionally reduces it into a
// signed inclusive range by a serial remainder; reseed loads a new seed.
//
//   channel  dir  signals
//   in_ch    in   valid, ready, cmd, seed_value, range_min, range_max
//   out_ch   out  valid, ready, value, seed_changed, range_error
//
// One request at a time. A next request makes two passes through the
// shared 4-phase multiplier; a range request adds a start state and the
// bit-serial remainder, both skipped when the bounds are inverted; a
// reseed goes straight to the result. Ready returns the cycle after the
// result loads into the output register.
// Reset clears the seed to zero and empties the output register.
// A stalled result holds in the output register; a new request is taken
// while it waits, and its result waits in turn until the output drains.
// ----------------------------------------------------------------------------
module splitmix_feedback_rng_range_top
  import smr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  smr_in_if.sink    in_ch,
  smr_out_if.source out_ch
);

  smr_state_t  state;
  smr_state_t  state_next;

  logic [63:0] seed;
  logic [63:0] k;
  logic [1:0]  cmd;
  logic [31:0] lo;
  logic [32:0] span;
  logic        rerr;

  logic [63:0] res_value;
  logic        res_changed;
  logic        res_error;

  logic        mul_start;
  logic        mul_done;
  logic [63:0] mul_a;
  logic [63:0] mul_b;
  logic [63:0] mul_prod;
  logic        mod_start;
  logic        mod_done;
  logic [32:0] mod_rem;

  logic        in_xfer;
  logic        out_free;
  logic [63:0] mix_fin;
  logic [32:0] diff33;
  logic        bad_bounds;

  assign in_xfer    = in_ch.valid && in_ch.ready;
  assign out_free   = !out_ch.valid || out_ch.ready;
  assign mix_fin    = mul_prod ^ (mul_prod >> 31);
  assign bad_bounds = in_ch.range_max < in_ch.range_min;
  assign diff33     = {in_ch.range_max[31], in_ch.range_max}
                    - {in_ch.range_min[31], in_ch.range_min};

  // Operand selection for the two mixing rounds
  assign mul_a = (state == S_MIX1) ? (k ^ (k >> 30)) : (k ^ (k >> 27));
  assign mul_b = (state == S_MIX1) ? MIX_MUL_A : MIX_MUL_B;

  smr_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_prod)
  );

  smr_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (k),
    .divisor  (span),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_ch.cmd == CMD_NEXT || in_ch.cmd == CMD_RANGE) begin
            state_next = S_MIX1;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_MIX1:  state_next = S_WAIT1;
      S_WAIT1: if (mul_done) state_next = S_MIX2;
      S_MIX2:  state_next = S_WAIT2;
      S_WAIT2: begin
        if (mul_done) begin
          state_next = (cmd == CMD_RANGE && !rerr) ? S_DIV : S_DONE;
        end
      end
      S_DIV:   state_next = S_WAITD;
      S_WAITD: if (mod_done) state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ch.ready = 1'b0;
    mul_start   = 1'b0;
    mod_start   = 1'b0;
    case (state)
      S_IDLE:  in_ch.ready = 1'b1;
      S_MIX1:  mul_start   = 1'b1;
      S_MIX2:  mul_start   = 1'b1;
      S_DIV:   mod_start   = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Seed register: reseed loads it, the second mixing round writes it back
  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= 64'd0;
    end else if (state == S_IDLE && in_xfer && in_ch.cmd == CMD_RESEED) begin
      seed <= in_ch.seed_value;
    end else if (state == S_WAIT2 && mul_done) begin
      seed <= mix_fin;
    end
  end

  // Working registers and result staging
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          cmd         <= in_ch.cmd;
          lo          <= in_ch.range_min;
          span        <= diff33 + 33'd1;
          rerr        <= bad_bounds;
          k           <= seed + GAMMA_ADD;
          res_value   <= 64'd0;
          res_changed <= 1'b0;
          res_error   <= 1'b0;
          if (in_ch.cmd == CMD_RESEED) begin
            res_value   <= in_ch.seed_value;
            res_changed <= in_ch.seed_value != seed;
          end
        end
      end
      S_WAIT1: if (mul_done) k <= mul_prod;
      S_WAIT2: begin
        if (mul_done) begin
          k <= mix_fin;
          if (cmd == CMD_RANGE) begin
            res_value <= 64'd0;
            res_error <= rerr;
          end else begin
            res_value <= mix_fin;
          end
        end
      end
      S_WAITD: begin
        if (mod_done) begin
          res_value <= {{32{lo[31]}}, lo} + {31'd0, mod_rem};
        end
      end
      default: ;
    endcase
  end

  // Output register: load when the result is ready and the slot is free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_ch.value        <= res_value;
      out_ch.seed_changed <= res_changed;
      out_ch.range_error  <= res_error;
    end
  end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the feedback splitmix generator with ranged output
// Drives next, ranged and reseed requests through the input channel and
// predicts each result with an independent model of the seed feedback, the
// signed range reduction and the reseed compare. Results are checked in
// order, field by field, under random stalls on both channels, one long
// output hold-off and two full drains of the pipeline.
// ----------------------------------------------------------------------------
import smr_pkg::*;

typedef struct packed {
  logic [63:0] value;
  logic        seed_changed;
  logic        range_error;
} rng_draw_t;

class rng_scoreboard;
  logic [63:0] seed;
  rng_draw_t   pending_draws[$];
  int          errors;

  function new();
    seed   = '0;
    errors = 0;
  endfunction

  // Step the seed: add gamma, two multiply-xorshift rounds, feed back
  function logic [63:0] mix_advance();
    logic [63:0] k;
    k = seed + GAMMA_ADD;
    k = (k ^ (k >> 30)) * MIX_MUL_A;
    k = (k ^ (k >> 27)) * MIX_MUL_B;
    k = k ^ (k >> 31);
    seed = k;
    return k;
  endfunction

  // Predict the result of an accepted request and queue it
  function void note_request(logic [1:0] cmd, logic [63:0] seed_value,
                             logic signed [31:0] lo, logic signed [31:0] hi);
    rng_draw_t   d;
    logic [63:0] word;
    logic [63:0] lo64;
    logic [63:0] hi64;
    logic [63:0] span;
    d = '0;
    case (cmd)
      CMD_NEXT: begin
        d.value = mix_advance();
      end
      CMD_RANGE: begin
        word = mix_advance();
        if (hi < lo) begin
          d.range_error = 1'b1;
        end else begin
          lo64    = {{32{lo[31]}}, lo};
          hi64    = {{32{hi[31]}}, hi};
          span    = hi64 - lo64 + 64'd1;
          d.value = lo64 + (word % span);
        end
      end
      CMD_RESEED: begin
        d.seed_changed = (seed_value != seed);
        seed           = seed_value;
        d.value        = seed_value;
      end
      default: ;
    endcase
    pending_draws.push_back(d);
  endfunction

  // Compare one delivered result with the oldest prediction
  function void check_result(logic [63:0] value, logic changed, logic err);
    rng_draw_t d;
    if (pending_draws.size() == 0) begin
      $display("%0t: unexpected result value=%h seed_changed=%b range_error=%b",
               $time, value, changed, err);
      errors++;
      return;
    end
    d = pending_draws.pop_front();
    if (value !== d.value) begin
      $display("%0t: value mismatch expected=%h actual=%h", $time, d.value, value);
      errors++;
    end
    if (changed !== d.seed_changed) begin
      $display("%0t: seed_changed mismatch expected=%b actual=%b",
               $time, d.seed_changed, changed);
      errors++;
    end
    if (err !== d.range_error) begin
      $display("%0t: range_error mismatch expected=%b actual=%b",
               $time, d.range_error, err);
      errors++;
    end
  endfunction
endclass

module tb_top;
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int PHASE_ITEMS  = 610;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE_CYCLES = 120;

  logic clk;
  logic rst;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   rx_hold_req;
  int   cycle_count;

  rng_scoreboard sb;

  smr_in_if  in_ch();
  smr_out_if out_ch();

  splitmix_feedback_rng_range_top DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: check each transfer, then pick ready for the next cycle
  initial begin : result_side
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.value, out_ch.seed_changed, out_ch.range_error);
      if (rx_hold_req != 0) begin
        stall_left  = rx_hold_req;
        rx_hold_req = 0;
      end
      if (rst) begin
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Offer one request and hold it until it transfers
  task automatic send_item(input logic [1:0] cmd, input logic [63:0] seed_value,
                           input logic signed [31:0] lo, input logic signed [31:0] hi);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= cmd;
    in_ch.seed_value <= seed_value;
    in_ch.range_min  <= lo;
    in_ch.range_max  <= hi;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_request(cmd, seed_value, lo, hi);
  endtask

  // Drop valid and wait until every predicted result has arrived
  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_draws.size() != 0) @(posedge clk);
  endtask

  // Random request, mostly well-formed bounds with some inverted ones
  task automatic send_random_item();
    int                 roll;
    logic [1:0]         cmd;
    logic [63:0]        new_seed;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic signed [31:0] t;
    roll     = $urandom_range(99);
    new_seed = {$urandom, $urandom};
    lo       = $urandom;
    hi       = $urandom;
    if (roll < 30) begin
      cmd = CMD_NEXT;
    end else if (roll < 80) begin
      cmd = CMD_RANGE;
      case ($urandom_range(4))
        0: begin
          lo = $signed(32'($urandom_range(20))) - 32'sd10;
          hi = $signed(32'($urandom_range(20))) - 32'sd10;
        end
        1: begin
          if ($urandom_range(1) == 0) lo = 32'sh8000_0000;
          else hi = 32'sh7fff_ffff;
        end
        2: hi = lo + $signed(32'($urandom_range(1000)));
        default: ;
      endcase
      if (hi < lo && $urandom_range(9) != 0) begin
        t  = lo;
        lo = hi;
        hi = t;
      end
    end else begin
      cmd = CMD_RESEED;
      case ($urandom_range(5))
        0: new_seed = sb.seed;
        1: new_seed = '0;
        2: new_seed = '1;
        default: ;
      endcase
    end
    send_item(cmd, new_seed, lo, hi);
  endtask

  initial begin
    sb               = new();
    clk              = 1'b0;
    rst              = 1'b1;
    cycle_count      = 0;
    rx_hold_req      = 0;
    tx_idle_pct      = 23;
    rx_idle_pct      = 54;
    in_ch.valid      = 1'b0;
    in_ch.cmd        = CMD_NEXT;
    in_ch.seed_value = '0;
    in_ch.range_min  = '0;
    in_ch.range_max  = '0;
    out_ch.ready     = 1'b0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: raw words from the reset seed, range extremes, inverted
    // bounds, reseed with and without a change
    send_item(CMD_NEXT,   64'd0, 32'sd0, 32'sd0);
    send_item(CMD_NEXT,   64'd0, 32'sd0, 32'sd0);
    send_item(CMD_RANGE,  64'd0, 32'sd0, 32'sd0);
    send_item(CMD_RANGE,  64'd0, 32'sh8000_0000, 32'sh7fff_ffff);
    send_item(CMD_RANGE,  64'd0, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_item(CMD_RANGE,  64'd0, 32'sh8000_0000, 32'sh8000_0000);
    send_item(CMD_RANGE,  64'd0, 32'sd1, 32'sd0);
    send_item(CMD_RANGE,  64'd0, 32'sh7fff_ffff, 32'sh8000_0000);
    send_item(CMD_RANGE,  64'd0, -32'sd5, 32'sd5);
    send_item(CMD_RANGE,  64'd0, -32'sd100, -32'sd50);
    send_item(CMD_RANGE,  64'd0, 32'sd0, 32'sh7fff_ffff);
    send_item(CMD_RESEED, 64'd0, 32'sd0, 32'sd0);
    send_item(CMD_RESEED, 64'd0, 32'sd0, 32'sd0);
    send_item(CMD_NEXT,   64'd0, 32'sd0, 32'sd0);
    send_item(CMD_RESEED, 64'hffff_ffff_ffff_ffff, 32'sd0, 32'sd0);
    send_item(CMD_RESEED, 64'hffff_ffff_ffff_ffff, 32'sd0, 32'sd0);
    send_item(CMD_NEXT,   64'd0, 32'sd0, 32'sd0);
    send_item(CMD_RESEED, 64'h8000_0000_0000_0000, 32'sd0, 32'sd0);
    send_item(CMD_RANGE,  64'd0, -32'sd1, 32'sd0);
    send_item(CMD_RESEED, 64'h5555_aaaa_3333_cccc, 32'sh5555_aaaa, 32'sh2aaa_5555);
    send_item(CMD_RANGE,  64'd0, 32'sh2aaa_5555, 32'sh5555_aaaa);

    // Sender sparse, receiver stalls often
    repeat (PHASE_ITEMS) send_random_item();

    // Pause the sender until the pipeline is empty
    wait_drain();

    // Long output hold-off while requests keep coming
    rx_hold_req = HOLD_CYCLES;
    tx_idle_pct = 0;
    repeat (6) send_random_item();

    // Sender stalls often, receiver sparse
    tx_idle_pct = 54;
    rx_idle_pct = 23;
    repeat (PHASE_ITEMS) send_random_item();

    // Back to back on both sides
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (PHASE_ITEMS) send_random_item();

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_draws.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

/* files.f */
hdl/smr_pkg.sv
hdl/smr_if.sv
hdl/smr_mul.sv
hdl/smr_mod.sv
hdl/splitmix_feedback_rng_range_top.sv
tb/sv/tb_top.sv
